>>> rtl/crc16_packet_serial_master_macros.svh
// Assertion helpers for the packet serial master
`ifndef CRC16_PACKET_SERIAL_MASTER_MACROS_SVH
`define CRC16_PACKET_SERIAL_MASTER_MACROS_SVH
// assert that a condition implies a consequence in the same cycle
`define CPS_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define CPS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/cps_pkg.sv
package cps_pkg;
    localparam int PACKET_BYTES_DEF = 48;
    localparam int STRING_MAX_DEF   = 48;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  ACK_BYTE = 8'hFF;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_RX    = 2'd2;
    localparam logic [1:0] FUNC_TICK  = 2'd3;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [1:0] REG_ADDR    = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_RETRY   = 2'd2;

    // request to the CRC unit and its reply
    typedef struct packed {
        logic       start;
        logic       clear;
        logic [7:0] data;
    } crc_req_t;

    typedef struct packed {
        logic        busy;
        logic [15:0] crc;
    } crc_stat_t;
endpackage

>>> rtl/cps_crc_unit.sv
// Bit-serial CRC-16 (0x1021), one bit per cycle
module cps_crc_unit
    import cps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  crc_req_t  req,
    output crc_stat_t stat
);
    logic [15:0] crc_reg;
    logic [7:0]  sh_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] fb;

    assign fb = {crc_reg[14:0], 1'b0} ^
                (((crc_reg[15] ^ sh_reg[7])) ? CRC_POLY : 16'h0000);

    // load a byte, then shift eight bits through the register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
            cnt_reg <= '0;
            sh_reg  <= '0;
        end
        else if (req.clear)
        begin
            crc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (req.start)
        begin
            sh_reg  <= req.data;
            cnt_reg <= 4'd8;
        end
        else if (cnt_reg != 4'd0)
        begin
            crc_reg <= fb;
            sh_reg  <= {sh_reg[6:0], 1'b0};
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    assign stat.busy = (cnt_reg != 4'd0);
    assign stat.crc  = crc_reg;
endmodule

>>> rtl/crc16_packet_serial_master.sv
// Host side of an addressed packet serial link with CRC-16 (poly 0x1021, init 0).
// A request is taken only while the sequencer is idle; the block then stays busy
// until all the work the request causes is done. Every address, request, resent or
// received data byte goes through the one bit-serial CRC unit, and the sequencer
// waits for the unit after each such byte; a resend reads the stored packet back
// one byte at a time. CRC bytes and the done result do not pass through the unit.
// A stall on the result side holds the sequencer. Results come out in order; tlast
// marks the last one of a request.
module crc16_packet_serial_master
    import cps_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int STRING_MAX   = STRING_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: byte_value[7:0], read_count[13:8], zero [15:14]
    input  logic [15:0] s_tdata,
    // tuser: func[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: value[7:0], success[8], zero [15:9]
    output logic [15:0] m_tdata,
    // tuser: kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
`include "crc16_packet_serial_master_macros.svh"
    localparam int LW = $clog2(PACKET_BYTES + 1);
    localparam int AW = $clog2(PACKET_BYTES);
    localparam int CW = 6;

    // link phases
    localparam logic [2:0] PH_IDLE = 3'd0, PH_COLLECT = 3'd1, PH_ACK = 3'd2,
                           PH_DATA = 3'd3, PH_CRCH = 3'd4, PH_CRCL = 3'd5;
    // sequencer steps
    localparam logic [3:0] S_IDLE = 4'd0, S_ADDR = 4'd1, S_BYTE = 4'd2,
                           S_CRCWAIT = 4'd3, S_CRCH = 4'd4, S_CRCL = 4'd5,
                           S_DONE = 4'd6, S_RESEND = 4'd7, S_RDWAIT = 4'd8,
                           S_RXDATA = 4'd9, S_FAIL = 4'd10, S_OUT = 4'd11,
                           S_DEC = 4'd12;

    logic [7:0]  addr_reg;
    logic [15:0] tmo_reg;
    logic [1:0]  retry_reg;

    logic [2:0]  phase_reg;
    logic [3:0]  st_reg, ret_reg;
    logic [LW-1:0] len_reg, idx_reg;
    logic [1:0]  att_reg;
    logic [15:0] timer_reg;
    logic [CW-1:0] exp_reg, rcv_reg;
    logic [7:0]  crch_reg;
    logic        rd_reg;
    logic [7:0]  b_reg;
    logic        last_reg;
    logic        ok_reg;
    logic [7:0]  mem [PACKET_BYTES];
    logic [7:0]  rd_data_reg;

    logic        ov_reg;
    logic [1:0]  okind_reg;
    logic [7:0]  oval_reg;
    logic        ook_reg, olast_reg;

    crc_req_t  creq;
    crc_stat_t cst;

    cps_crc_unit u_crc (.clk(clk), .rst_n(rst_n), .req(creq), .stat(cst));

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= 8'd128;
            tmo_reg   <= 16'd1000;
            retry_reg <= 2'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ADDR:    addr_reg  <= cfg_data[7:0];
                REG_TIMEOUT: tmo_reg   <= cfg_data;
                REG_RETRY:   retry_reg <= cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    assign s_tready = (st_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {7'd0, ook_reg, oval_reg};
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

    logic [CW-1:0] cnt_in, rcv_inc;
    assign cnt_in  = (s_tdata[13:8] > CW'(STRING_MAX)) ? CW'(STRING_MAX) : s_tdata[13:8];
    assign rcv_inc = rcv_reg + CW'(1);

    // stored packet: one write and one registered read port
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]    mem_wd;
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end
    assign mem_ra = idx_reg[AW-1:0];

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; ret_reg <= S_IDLE; phase_reg <= PH_IDLE;
            len_reg <= '0; idx_reg <= '0; att_reg <= '0; timer_reg <= '0;
            exp_reg <= '0; rcv_reg <= '0; crch_reg <= '0; rd_reg <= 1'b0;
            ov_reg <= 1'b0; okind_reg <= KIND_TX; oval_reg <= '0;
            ook_reg <= 1'b0; olast_reg <= 1'b0;
            b_reg <= '0; last_reg <= 1'b0; ok_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && m_tready)
                ov_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        b_reg    <= s_tdata[7:0];
                        last_reg <= s_tlast;
                        st_reg   <= S_IDLE;
                        case (s_tuser)
                            FUNC_WRITE:
                            begin
                                if (phase_reg == PH_IDLE)
                                begin
                                    rd_reg <= 1'b0; att_reg <= '0; len_reg <= '0;
                                    phase_reg <= PH_COLLECT;
                                    st_reg <= S_ADDR;
                                end
                                else if (phase_reg == PH_COLLECT)
                                    st_reg <= S_BYTE;
                            end
                            FUNC_READ:
                            begin
                                if (phase_reg == PH_IDLE)
                                begin
                                    rd_reg <= 1'b1; att_reg <= '0; len_reg <= '0;
                                    exp_reg <= cnt_in; rcv_reg <= '0; timer_reg <= '0;
                                    last_reg <= 1'b0;
                                    phase_reg <= PH_DATA;
                                    st_reg <= S_ADDR;
                                end
                            end
                            FUNC_RX:
                            begin
                                timer_reg <= '0;
                                case (phase_reg)
                                    PH_ACK:
                                    begin
                                        if (s_tdata[7:0] == ACK_BYTE)
                                        begin
                                            ok_reg <= 1'b1; st_reg <= S_DONE;
                                        end
                                        else
                                            st_reg <= S_FAIL;
                                    end
                                    PH_DATA: st_reg <= S_RXDATA;
                                    PH_CRCH:
                                    begin
                                        crch_reg <= s_tdata[7:0];
                                        phase_reg <= PH_CRCL;
                                    end
                                    PH_CRCL:
                                    begin
                                        if ({crch_reg, s_tdata[7:0]} == cst.crc)
                                        begin
                                            ok_reg <= 1'b1; st_reg <= S_DONE;
                                        end
                                        else
                                            st_reg <= S_FAIL;
                                    end
                                    default: ;
                                endcase
                            end
                            default:
                            begin
                                if (phase_reg >= PH_ACK && phase_reg <= PH_CRCL)
                                begin
                                    timer_reg <= timer_reg + 16'd1;
                                    if (timer_reg + 16'd1 >= tmo_reg)
                                        st_reg <= S_FAIL;
                                end
                            end
                        endcase
                    end
                end
                // emit address (as a stored byte)
                S_ADDR:
                begin
                    if (!ov_reg)
                    begin
                        len_reg <= LW'(1);
                        okind_reg <= KIND_TX; oval_reg <= addr_reg; ook_reg <= 1'b0;
                        olast_reg <= 1'b0; ov_reg <= 1'b1;
                        ret_reg <= S_BYTE; st_reg <= S_CRCWAIT;
                    end
                end
                // emit the request byte if room remains
                S_BYTE:
                begin
                    if (!ov_reg && !cst.busy)
                    begin
                        if (len_reg < LW'(PACKET_BYTES))
                        begin
                            len_reg <= len_reg + LW'(1);
                            okind_reg <= KIND_TX; oval_reg <= b_reg; ook_reg <= 1'b0;
                            olast_reg <= rd_reg || !last_reg; ov_reg <= 1'b1;
                            ret_reg <= rd_reg ? S_RDWAIT : (last_reg ? S_CRCH : S_IDLE);
                            st_reg <= S_CRCWAIT;
                        end
                        else
                            st_reg <= rd_reg ? S_RDWAIT : (last_reg ? S_CRCH : S_IDLE);
                    end
                end
                S_CRCWAIT:
                    if (!cst.busy && !creq.start) st_reg <= ret_reg;
                S_RDWAIT:
                begin
                    if (!ov_reg)
                    begin
                        olast_reg <= 1'b0;
                        st_reg <= S_IDLE;
                    end
                end
                S_CRCH:
                begin
                    if (!ov_reg && !cst.busy)
                    begin
                        okind_reg <= KIND_TX; oval_reg <= cst.crc[15:8]; ook_reg <= 1'b0;
                        olast_reg <= 1'b0; ov_reg <= 1'b1; st_reg <= S_CRCL;
                    end
                end
                S_CRCL:
                begin
                    if (!ov_reg)
                    begin
                        okind_reg <= KIND_TX; oval_reg <= cst.crc[7:0];
                        olast_reg <= 1'b1; ov_reg <= 1'b1;
                        phase_reg <= PH_ACK; timer_reg <= '0; st_reg <= S_IDLE;
                    end
                end
                S_DONE:
                begin
                    if (!ov_reg)
                    begin
                        okind_reg <= KIND_DONE; oval_reg <= '0; ook_reg <= ok_reg;
                        olast_reg <= 1'b1; ov_reg <= 1'b1; ok_reg <= 1'b0;
                        phase_reg <= PH_IDLE; st_reg <= S_IDLE;
                    end
                end
                S_FAIL:
                begin
                    if (att_reg < retry_reg)
                    begin
                        att_reg <= att_reg + 2'd1;
                        idx_reg <= '0; st_reg <= S_RESEND; ret_reg <= S_RESEND;
                    end
                    else
                    begin
                        ok_reg <= 1'b0; st_reg <= S_DONE;
                    end
                end
                // walk the stored packet through the registered read port
                S_RESEND:
                begin
                    if (idx_reg == len_reg)
                    begin
                        rcv_reg <= '0; timer_reg <= '0;
                        if (rd_reg)
                        begin
                            phase_reg <= PH_DATA; st_reg <= S_RDWAIT;
                        end
                        else
                            st_reg <= S_CRCH;
                    end
                    else
                        st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ov_reg && !cst.busy)
                    begin
                        okind_reg <= KIND_TX; oval_reg <= rd_data_reg; ook_reg <= 1'b0;
                        olast_reg <= rd_reg && (idx_reg + LW'(1) == len_reg);
                        ov_reg <= 1'b1; idx_reg <= idx_reg + LW'(1);
                        st_reg <= S_DEC;
                    end
                end
                S_DEC:
                    st_reg <= S_CRCWAIT;
                S_RXDATA:
                begin
                    if (!ov_reg)
                    begin
                        rcv_reg <= rcv_inc;
                        okind_reg <= KIND_DATA; oval_reg <= b_reg; ook_reg <= 1'b0;
                        ov_reg <= 1'b1; olast_reg <= 1'b1; st_reg <= S_CRCWAIT;
                        ret_reg <= S_IDLE;
                        if (exp_reg != '0)
                        begin
                            if (rcv_inc >= exp_reg) phase_reg <= PH_CRCH;
                        end
                        else if (b_reg == 8'd0)
                            phase_reg <= PH_CRCH;
                        else if (rcv_inc >= CW'(STRING_MAX))
                        begin
                            olast_reg <= 1'b0; ret_reg <= S_FAIL;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // a new packet starts when a write or read request is taken while idle
    logic new_pkt;
    assign new_pkt = s_tvalid && s_tready && phase_reg == PH_IDLE &&
                     (s_tuser == FUNC_WRITE || s_tuser == FUNC_READ);

    // feed the CRC unit whenever an address, request, resent or received byte goes out
    logic emit_now;
    assign emit_now = (st_reg == S_ADDR && !ov_reg) ||
                      (st_reg == S_BYTE && !ov_reg && !cst.busy &&
                       len_reg < LW'(PACKET_BYTES)) ||
                      (st_reg == S_OUT && !ov_reg && !cst.busy) ||
                      (st_reg == S_RXDATA && !ov_reg);
    always_comb
    begin
        creq.clear = new_pkt ||
                     (st_reg == S_FAIL && att_reg < retry_reg);
        creq.start = emit_now;
        case (st_reg)
            S_ADDR:  creq.data = addr_reg;
            S_OUT:   creq.data = rd_data_reg;
            default: creq.data = b_reg;
        endcase
    end

    // store address and request bytes of a new packet
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = b_reg;
        if (st_reg == S_ADDR && !ov_reg)
        begin
            mem_we = 1'b1; mem_wd = addr_reg;
        end
        else if (st_reg == S_BYTE && !ov_reg && !cst.busy && len_reg < LW'(PACKET_BYTES))
        begin
            mem_we = 1'b1; mem_wa = len_reg[AW-1:0];
        end
    end

    // remember that a new packet was just taken
    logic crc_fresh_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) crc_fresh_reg <= 1'b0;
        else        crc_fresh_reg <= new_pkt;
    end

    `CPS_ASSERT_IMPL(a_busy_no_ready, clk, rst_n, cst.busy, !s_tready,
                     "accepting a request while the CRC unit runs")
    `CPS_ASSERT_NEXT(a_new_clears, clk, rst_n, new_pkt, st_reg == S_ADDR,
                     "new packet did not start with the address")
    `CPS_ASSERT_IMPL(a_len_bound, clk, rst_n, 1'b1, len_reg <= LW'(PACKET_BYTES),
                     "packet length beyond store")
    `CPS_ASSERT_IMPL(a_fresh_crc, clk, rst_n, crc_fresh_reg, phase_reg != PH_IDLE,
                     "packet start left link idle")
endmodule
